// ===== hdl/lcv_pkg.sv =====
// ----------------------------------------------------------------------------
// lcv_pkg
// Shared constants, result type and character helpers for the cursor checker.
// ----------------------------------------------------------------------------
package lcv_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned SEC_W   = 3;
	localparam int unsigned OFF_W   = 2;
	localparam int unsigned M_DATA_W = 16;

	localparam logic [BYTE_W-1:0] EXPECTED_LENGTH_RESET = 8'd122;
	localparam logic [POS_W-1:0]  COUNT_MAX             = 8'd255;
	localparam logic [POS_W-1:0]  LENGTH_NONE           = 8'd0;

	// section codes
	localparam logic [SEC_W-1:0] SEC_S = 3'd0;
	localparam logic [SEC_W-1:0] SEC_I = 3'd1;
	localparam logic [SEC_W-1:0] SEC_B = 3'd2;
	localparam logic [SEC_W-1:0] SEC_M = 3'd3;
	localparam logic [SEC_W-1:0] SEC_T = 3'd4;
	localparam logic [SEC_W-1:0] SEC_X = 3'd5;

	localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B; // ';'
	localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D; // '='
	localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

	typedef struct packed {
		logic             valid_res;
		logic [POS_W-1:0] stop_position;
	} lcv_result_t;

	function automatic logic is_hex(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
		       (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [OFF_W-1:0] pfx_len(input logic [SEC_W-1:0] sec);
		return (sec == SEC_S) ? 2'd2 : 2'd3;
	endfunction

	function automatic logic [BYTE_W-1:0] pfx_char(input logic [SEC_W-1:0] sec,
	                                               input logic [OFF_W-1:0] off);
		logic [BYTE_W-1:0] tag;
		unique case (sec)
			SEC_S:   tag = 8'h73; // 's'
			SEC_I:   tag = 8'h69; // 'i'
			SEC_B:   tag = 8'h62; // 'b'
			SEC_M:   tag = 8'h6D; // 'm'
			SEC_T:   tag = 8'h74; // 't'
			default: tag = 8'h78; // 'x'
		endcase
		if (sec == SEC_S) begin
			unique case (off)
				2'd0:    return tag;
				2'd1:    return CH_EQ;
				default: return CH_NUL;
			endcase
		end else begin
			unique case (off)
				2'd0:    return CH_SEMI;
				2'd1:    return tag;
				default: return CH_EQ;
			endcase
		end
	endfunction

endpackage

// ===== hdl/lcv_parser.sv =====
// ----------------------------------------------------------------------------
// lcv_parser
// Parse state of the cursor string; advances one byte per step and forms the
// result on the last byte.
// ----------------------------------------------------------------------------
module lcv_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [lcv_pkg::BYTE_W-1:0]  char_byte,
	input  logic                        last,
	input  logic [lcv_pkg::BYTE_W-1:0]  expected_length,
	output lcv_pkg::lcv_result_t        res
);
	import lcv_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0] byte_count;
		logic [SEC_W-1:0] section;
		logic [OFF_W-1:0] prefix_offset;
		logic             scanning;
		logic             stopped;
		logic [POS_W-1:0] stop_index;
		logic [POS_W-1:0] prefix_start;
	} pstate_t;

	pstate_t st_q;
	pstate_t st_nxt;
	pstate_t st_upd;

	function automatic pstate_t check_char(input pstate_t s, input logic [BYTE_W-1:0] c);
		pstate_t          r;
		logic [SEC_W-1:0] sec;
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] len;
		r   = s;
		sec = (s.section > SEC_X) ? SEC_X : s.section;
		off = (s.prefix_offset == 2'd3) ? 2'd2 : s.prefix_offset;
		len = pfx_len(sec);
		if (off < len && c == pfx_char(sec, off)) begin
			r.prefix_offset = 2'(off + 2'd1);
			if (2'(off + 2'd1) >= len) begin
				r.scanning = 1'b1;
			end
		end else begin
			r.stopped    = 1'b1;
			r.stop_index = s.prefix_start;
		end
		return r;
	endfunction

	function automatic pstate_t open_next(input pstate_t s, input logic [BYTE_W-1:0] c);
		pstate_t r;
		r               = s;
		r.section       = 3'(s.section + 3'd1);
		r.prefix_start  = s.byte_count;
		r.prefix_offset = '0;
		r.scanning      = 1'b0;
		return check_char(r, c);
	endfunction

	always_comb begin
		st_upd = st_q;
		if (!st_q.stopped) begin
			if (!st_q.scanning) begin
				st_upd = check_char(st_q, char_byte);
			end else if (st_q.section == SEC_S) begin
				if (char_byte == CH_SEMI) begin
					st_upd = open_next(st_q, char_byte);
				end
			end else if (is_hex(char_byte)) begin
				st_upd = st_q;
			end else if (st_q.section >= SEC_X) begin
				st_upd.stopped    = 1'b1;
				st_upd.stop_index = st_q.byte_count;
			end else begin
				st_upd = open_next(st_q, char_byte);
			end
		end
		if (st_q.byte_count != COUNT_MAX) begin
			st_upd.byte_count = 8'(st_q.byte_count + 8'd1);
		end
	end

	always_comb begin
		res = '0;
		if (expected_length == LENGTH_NONE || expected_length == COUNT_MAX ||
		    st_upd.byte_count != expected_length) begin
			res = '0;
		end else if (st_upd.stopped) begin
			res.stop_position = st_upd.stop_index;
		end else if (!st_upd.scanning) begin
			res.stop_position = st_upd.prefix_start;
		end else begin
			res.stop_position = st_upd.byte_count;
			res.valid_res     = (st_upd.section == SEC_X);
		end
	end

	// clear after the last byte so the next string starts fresh
	assign st_nxt = last ? pstate_t'('0) : st_upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule

// ===== hdl/log_cursor_validator_top.sv =====
// ----------------------------------------------------------------------------
// log_cursor_validator_top
// Streams a cursor string in byte by byte and reports its validity.
// ----------------------------------------------------------------------------
// One byte per cycle goes in on the slave stream while s_tready is high; s_tlast
// closes a string. The byte waits in an input register while the parser updates
// its state, and on the last byte the result is loaded into the output register,
// so a result passes the input register and then the output register. The input
// side keeps taking a byte every cycle as long as the output register can be
// emptied; a held result stalls input only when a second last byte arrives
// behind it. Write expected_length only while no string is in flight.
module log_cursor_validator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lcv_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] char_byte
	input  logic                          s_tlast,  // last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lcv_pkg::M_DATA_W-1:0]  m_tdata,  // [0] valid_res, [8:1] stop_position
	input  logic                          cfg_wr_en,
	input  logic [lcv_pkg::BYTE_W-1:0]    cfg_wr_data
);
	import lcv_pkg::*;

	logic [BYTE_W-1:0] expected_length_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              advance;
	logic              out_free;
	lcv_result_t       res;
	lcv_result_t       res_q;
	logic              out_valid_q;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_length_q <= EXPECTED_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			expected_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	lcv_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.char_byte       (byte_s1),
		.last            (last_s1),
		.expected_length (expected_length_q),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the sink takes it
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({res_q.stop_position, res_q.valid_res});

endmodule

// ===== hdl/lcv_checker.sv =====
// ----------------------------------------------------------------------------
// lcv_checker
// Port-level checks for the cursor checker, bound to the top level.
// ----------------------------------------------------------------------------
module lcv_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         s_tlast,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [lcv_pkg::M_DATA_W-1:0] m_tdata
);
	import lcv_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[8:1] != 8'd0)
		else $error("valid result with zero stop position");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result beat without a last input beat");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output is free");

endmodule

bind log_cursor_validator_top lcv_checker u_lcv_checker (.*);
